// File: src/positional_ordered_list_unit_assert.svh
// Assertion macros for the positional ordered list unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`ifndef SYNTH
// Clocked check, switched off while reset is held
`define POL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Clocked check that also runs during reset
`define POL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define POL_ASSERT(lbl, prop, msg)
`define POL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/pol_pkg.sv
// Shared types and constants for the positional ordered list unit.
// No dependencies; imported by pol_cell, positional_ordered_list_unit and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

    // Default sizes
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed field widths of the stream beats
    localparam int TYPE_W  = 2;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 5;

    // Request kinds
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_READ   = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd3;

    // Broadcast control for the cell row
    typedef struct packed {
        logic ins;   // insert at position, later entries shift up
        logic rem;   // remove at position, later entries shift down
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: src/pol_cell.sv
// One storage cell of the list row: holds a single entry.
// Depends on pol_pkg (t_cell_ctl).
`timescale 1ns / 1ps
`default_nettype none

module pol_cell
    import pol_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int PW         = 5,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire                   i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire [PW-1:0]          i_pos,
    input  wire [DATA_WIDTH-1:0]  i_data,
    input  wire [DATA_WIDTH-1:0]  i_left,   // entry of the cell below
    input  wire [DATA_WIDTH-1:0]  i_right,  // entry of the cell above
    output logic [DATA_WIDTH-1:0] o_q
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] n_q;

    // Pick the new contents from the neighbours or the request
    always_comb begin
        n_q = r_q;
        if (i_ctl.ins && (MY_IDX > i_pos)) begin
            n_q = i_left;
        end else if (i_ctl.ins && (MY_IDX == i_pos)) begin
            n_q = i_data;
        end else if (i_ctl.rem && (MY_IDX >= i_pos)) begin
            n_q = i_right;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// File: src/positional_ordered_list_unit.sv
// Positional ordered list: the result beat is registered in the output register
// in the cycle after the input beat is taken; one beat per cycle sustained while
// results are drained, since the whole cell row shifts in the same cycle on insert
// or remove and reads go through one position mux. Input is taken whenever the
// output register is empty or being drained. Reset (synchronous, active low) empties
// the list and the output register; stored words stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

`include "positional_ordered_list_unit_assert.svh"

module positional_ordered_list_unit
    import pol_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [39:0] i_s_axis_tdata,   // position[4:0], value[36:5], zero pad
    input  wire  [1:0]  i_s_axis_tuser,   // req_type[1:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // read_value[31:0], length[36:32], empty_res[37]
    output logic [0:0]  o_m_axis_tuser    // ok[0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Input beat fields
    logic [TYPE_W-1:0]     w_type;
    logic [POS_W-1:0]      w_pos;
    logic [VALUE_W-1:0]    w_value;
    logic [PW-1:0]         w_pos_x;
    logic [PW-1:0]         w_cnt_x;
    logic [DATA_WIDTH-1:0] w_data;
    logic                  w_acc;

    assign w_type  = i_s_axis_tuser;
    assign w_pos   = i_s_axis_tdata[POS_W-1:0];
    assign w_value = i_s_axis_tdata[POS_W+VALUE_W-1:POS_W];
    assign w_pos_x = PW'(w_pos);
    assign w_data  = DATA_WIDTH'(w_value);

    // Control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;

    // Output payload
    logic [VALUE_W-1:0] r_rd;
    logic [LEN_W-1:0]   r_len;
    logic               r_empty;
    logic               r_ok;

    assign w_cnt_x         = PW'(r_count);
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // Cell row
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_cell_q [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell_q[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell_q[gi+1];
            end
            pol_cell #(
                .IDX        (gi),
                .PW         (PW),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_pos   (w_pos_x),
                .i_data  (w_data),
                .i_left  (w_left),
                .i_right (w_right),
                .o_q     (w_cell_q[gi])
            );
        end
    endgenerate

    // Request decode and result
    logic                  w_in_range;
    logic                  w_ins_ok;
    logic                  n_ok;
    logic [DATA_WIDTH-1:0] w_rd_word;
    logic [VALUE_W-1:0]    n_rd;

    assign w_in_range = w_pos_x < w_cnt_x;
    assign w_ins_ok   = (w_pos_x <= w_cnt_x) && (r_count < CNT_W'(CAPACITY));
    assign w_rd_word  = w_cell_q[w_pos_x[IDX_W-1:0]];

    always_comb begin
        n_ok      = 1'b0;
        n_count   = r_count;
        n_rd      = '0;
        w_ctl.ins = 1'b0;
        w_ctl.rem = 1'b0;
        unique case (w_type)
            REQ_INSERT: begin
                n_ok      = w_ins_ok;
                w_ctl.ins = w_acc && w_ins_ok;
                if (w_ins_ok) begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_REMOVE: begin
                n_ok      = w_in_range;
                w_ctl.rem = w_acc && w_in_range;
                if (w_in_range) begin
                    n_count = r_count - 1'b1;
                end
            end
            REQ_READ: begin
                n_ok = w_in_range;
                if (w_in_range) begin
                    n_rd = VALUE_W'(w_rd_word);
                end
            end
            REQ_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Length and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result beat payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ok    <= n_ok;
            r_rd    <= n_rd;
            r_len   <= LEN_W'(n_count);
            r_empty <= (n_count == '0);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_empty, r_len, r_rd};
    assign o_m_axis_tuser  = r_ok;

    // Checks
    `POL_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "list length beyond capacity")
    `POL_ASSERT(a_clear_empties, (w_acc && (w_type == REQ_CLEAR)) |=> (r_count == '0), "clear left entries")
    `POL_ASSERT(a_insert_grows, (w_acc && w_ctl.ins) |=> (r_count == $past(r_count) + 1'b1), "insert did not grow list")
    `POL_ASSERT(a_empty_flag, r_out_valid |-> (r_empty == (r_len == '0)), "empty flag disagrees with length")
    `POL_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_out_valid, "result beat after reset")

endmodule

`default_nettype wire

// File: dv/positional_ordered_list_unit_test.sv
// Self-checking testbench for positional_ordered_list_unit: directed and random request
// streams against a behavioural list model, with back-pressure on both stream sides.
// Depends on pol_pkg and the positional_ordered_list_unit RTL.
`timescale 1ns / 1ps

module positional_ordered_list_unit_test;
    import pol_pkg::*;

    localparam int LIST_CAP        = DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    // One result beat as the block reports it
    typedef struct packed {
        logic             ok;
        logic [31:0]      rd_word;
        logic [LEN_W-1:0] len;
        logic             empty;
    } t_outcome;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;   // position[4:0], value[36:5], zero pad
    logic [1:0]  i_s_axis_tuser  = '0;   // req_type[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;         // read_value[31:0], length[36:32], empty_res[37]
    logic [0:0]  o_m_axis_tuser;         // ok[0]

    // Model of the list contents and the outcomes still to come
    logic [31:0] list_words [LIST_CAP];
    int          list_len      = 0;
    t_outcome    pending_outcomes [$];

    int fail_count    = 0;
    int idle_cycles   = 0;
    int hold_request  = 0;
    bit tx_gaps       = 1'b0;
    bit rx_stalls     = 1'b0;
    bit growing       = 1'b1;

    positional_ordered_list_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the model list and return the outcome it should give
    function automatic t_outcome apply_list_op(input logic [TYPE_W-1:0] kind,
                                               input logic [POS_W-1:0] pos,
                                               input logic [VALUE_W-1:0] value);
        t_outcome res;
        res = '0;
        case (kind)
            REQ_INSERT: begin
                if (pos <= list_len && list_len < LIST_CAP) begin
                    for (int i = list_len; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = value;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (pos < list_len) begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            REQ_READ: begin
                if (pos < list_len) begin
                    res.rd_word = list_words[pos];
                    res.ok      = 1'b1;
                end
            end
            default: begin
                // clear keeps the stored words, only the length drops
                list_len = 0;
                res.ok   = 1'b1;
            end
        endcase
        res.len   = list_len[LEN_W-1:0];
        res.empty = (list_len == 0);
        return res;
    endfunction

    // Offer one request beat, wait for it to be taken, then maybe pause
    task automatic send_req(input logic [TYPE_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] value);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {3'b000, value, pos};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_outcomes.push_back(apply_list_op(kind, pos, value));
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every outstanding result has come back
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed edits that swing the list between empty and full
    task automatic random_op();
        int                 r;
        logic [TYPE_W-1:0]  kind;
        logic [POS_W-1:0]   pos;
        if (list_len == LIST_CAP)
            growing = 1'b0;
        else if (list_len == 0)
            growing = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 1 && !growing) begin
            kind = REQ_CLEAR;
            pos  = POS_W'($urandom_range(0, 31));
        end else if (r < 12) begin
            // noise: any kind but clear, any position
            kind = TYPE_W'($urandom_range(0, 2));
            pos  = POS_W'($urandom_range(0, 31));
        end else if (r < (growing ? 57 : 32)) begin
            kind = REQ_INSERT;
            pos  = POS_W'($urandom_range(0, list_len));
        end else begin
            kind = (r < (growing ? 75 : 62)) ? REQ_READ : REQ_REMOVE;
            pos  = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
        end
        send_req(kind, pos, $urandom);
    endtask

    // Empty list: every positional request fails, clear still succeeds
    task automatic test_empty_list();
        send_req(REQ_READ, 5'd0, 32'h0);
        send_req(REQ_REMOVE, 5'd0, 32'h0);
        send_req(REQ_CLEAR, 5'd0, 32'h0);
        send_req(REQ_INSERT, 5'd1, 32'h1234_5678);
        send_req(REQ_READ, 5'd31, 32'h0);
        send_req(REQ_REMOVE, 5'd31, 32'h0);
        send_req(REQ_INSERT, 5'd31, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    // Insert at front, end and middle; read back; remove ends; clear
    task automatic test_edit_and_read();
        send_req(REQ_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_req(REQ_INSERT, 5'd0, 32'h0000_0000);
        send_req(REQ_INSERT, 5'd2, 32'hA5A5_A5A5);
        send_req(REQ_INSERT, 5'd1, 32'h5A5A_5A5A);
        for (int i = 0; i < 4; i++)
            send_req(REQ_READ, i[POS_W-1:0], 32'hDEAD_BEEF);
        send_req(REQ_INSERT, 5'd5, 32'h0BAD_F00D);
        send_req(REQ_REMOVE, 5'd3, 32'h0);
        send_req(REQ_REMOVE, 5'd0, 32'h0);
        send_req(REQ_READ, 5'd0, 32'h0);
        send_req(REQ_READ, 5'd1, 32'h0);
        send_req(REQ_READ, 5'd2, 32'h0);
        send_req(REQ_CLEAR, 5'd17, 32'h0);
        send_req(REQ_READ, 5'd0, 32'h0);
        wait_drained();
    endtask

    // Fill to capacity; inserts then fail, the last position of the full list reads back
    task automatic test_fill_to_capacity();
        while (list_len < LIST_CAP)
            send_req(REQ_INSERT, POS_W'($urandom_range(0, list_len)), $urandom);
        send_req(REQ_INSERT, 5'd16, 32'h1111_1111);
        send_req(REQ_INSERT, 5'd0, 32'h2222_2222);
        send_req(REQ_READ, 5'd15, 32'h0);
        send_req(REQ_READ, 5'd16, 32'h0);
        send_req(REQ_REMOVE, 5'd7, 32'h0);
        send_req(REQ_INSERT, 5'd15, 32'h3333_3333);
        send_req(REQ_READ, 5'd15, 32'h0);
        send_req(REQ_CLEAR, 5'd0, 32'h0);
        send_req(REQ_READ, 5'd0, 32'h0);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_output_hold_off();
        tx_gaps      = 1'b0;
        rx_stalls    = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (40) random_op();
        wait_drained();
    endtask

    // Random traffic with idling switched on and off in chunks
    task automatic test_random_traffic(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                tx_gaps   = ($urandom_range(0, 2) != 0);
                rx_stalls = ($urandom_range(0, 2) != 0);
            end
            random_op();
        end
        wait_drained();
    endtask

    // Back-to-back traffic, no idling on either side
    task automatic test_full_rate(input int n_items);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        repeat (n_items) random_op();
        wait_drained();
    endtask

    // Result sink: long hold-off on request, otherwise random stall bursts
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
                i_m_axis_tready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic bit field_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Compare every result beat with the oldest outstanding outcome
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        bit       bad;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual tdata=%h tuser=%h",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                bad  = 1'b0;
                bad |= field_mismatch("ok", 32'(want.ok), 32'(o_m_axis_tuser[0]));
                bad |= field_mismatch("read_value", want.rd_word, o_m_axis_tdata[31:0]);
                bad |= field_mismatch("length", 32'(want.len), 32'(o_m_axis_tdata[36:32]));
                bad |= field_mismatch("empty_res", 32'(want.empty), 32'(o_m_axis_tdata[37]));
                if (bad)
                    fail_count++;
            end
        end
    end

    // Watchdog: too long without a beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                     || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("** positional_ordered_list_unit: FAILED **");
            $finish;
        end
    end

    // Test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        test_empty_list();
        test_edit_and_read();
        test_fill_to_capacity();
        test_output_hold_off();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        test_fill_to_capacity();
        test_random_traffic(1250);
        test_full_rate(300);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("** positional_ordered_list_unit: PASSED **");
        else
            $display("** positional_ordered_list_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/pol_pkg.sv
src/pol_cell.sv
src/positional_ordered_list_unit.sv
dv/positional_ordered_list_unit_test.sv
